// ===== src/sorted_multi_timer_queue_core_assert.svh =====
// Assertion macros used by the timer queue core.
`ifndef SORTED_MULTI_TIMER_QUEUE_CORE_ASSERT_SVH
`define SORTED_MULTI_TIMER_QUEUE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge outside reset.
`define SMTQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define SMTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SMTQ_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SMTQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/smtq_pkg.sv =====
package smtq_pkg;

   localparam int TIME_W    = 32;
   localparam int ID_W      = 8;
   localparam int DEPTH_DEF = 16;

   typedef enum logic [2:0] {
      K_ARM, K_CLR_ID, K_CLR_ALL, K_FRAME_ON, K_FRAME_OFF, K_TICK, K_PAUSE, K_RESUME
   } kind_type;

   typedef enum logic [1:0] {
      EV_EXPIRED = 2'd0, EV_FRAME = 2'd1, EV_REJECT = 2'd2
   } event_type;

   typedef enum logic [2:0] {
      S_IDLE, S_BUB, S_CLR, S_ROT, S_FIRE
   } state_type;

   // Per-cell operation for the current cycle.
   typedef enum logic [2:0] {
      C_HOLD, C_LOAD, C_TAKE_L, C_TAKE_R, C_SHIFT, C_REARM
   } cell_op_type;

   typedef struct packed {
      logic [TIME_W-1:0] ft;
      logic [TIME_W-1:0] rl;
      logic              rep;
      logic [ID_W-1:0]   owner;
   } entry_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic [TIME_W-1:0] key;
      logic [ID_W-1:0]   id;
      entry_type         ent;
   } bus_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] period;
      logic              periodic;
      logic [ID_W-1:0]   timer_id;
   } req_type;

   typedef struct packed {
      logic [1:0]        event_res;
      logic [ID_W-1:0]   fired_id;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] frame_elapsed;
      logic              last;
   } rsp_type;

endpackage

// ===== src/smtq_cell.sv =====
module smtq_cell (
   input  logic                 clock,
   input  smtq_pkg::cell_op_type op,
   input  smtq_pkg::bus_type    bus,
   input  smtq_pkg::entry_type  left_ent,
   input  smtq_pkg::entry_type  right_ent,
   output smtq_pkg::entry_type  ent,
   output logic                 gt,
   output logic                 match
);
   import smtq_pkg::*;

   entry_type         ent_ff;
   logic [TIME_W-1:0] sum;

   // One adder serves both the resume shift and the re-arm time.
   assign sum   = ((op == C_REARM) ? ent_ff.rl : ent_ff.ft) + bus.key;
   assign ent   = ent_ff;
   assign gt    = ent_ff.ft > bus.key;
   assign match = ent_ff.owner == bus.id;

   always_ff @(posedge clock) begin
      case (op)
         C_LOAD:   ent_ff <= bus.ent;
         C_TAKE_L: ent_ff <= left_ent;
         C_TAKE_R: ent_ff <= right_ent;
         C_SHIFT,
         C_REARM:  ent_ff.ft <= sum;
         default:  ent_ff <= ent_ff;
      endcase
   end

endmodule

// ===== src/sorted_multi_timer_queue_core.sv =====
// Channel  | Ports                   | Handshake
// request  | start, busy, req_data   | word taken at a clock edge with start high, busy low
// response | rsp_strobe, rsp_data    | word shown for one cycle, taken at its closing edge
//
// Order of work: frame, clear-all, pause and resume words, an arm into an empty
// queue, a rejected arm and a tick while paused are done in the idle state. Any other
// arm word bubbles its entry past each later-firing entry, one swap per step. A clear-id
// word removes its matching entries one by one. A tick rotates each expired entry out
// and then reports each one; a periodic timer is re-inserted by bubbling after its
// report. Only one compare-and-swap between neighbor cells happens per step.
// Reset is synchronous and active high; it empties the queue and clears frame and
// pause state. The receiver cannot stall: results leave as they are made.
module sorted_multi_timer_queue_core #(
   parameter int DEPTH = smtq_pkg::DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  smtq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output smtq_pkg::rsp_type rsp_data
);
   import smtq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam logic [OCC_W-1:0] FULL = OCC_W'(DEPTH);

   // Each cell holds one queue entry; entries below the occupancy count are live.
   state_type         state_ff, state_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [OCC_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic              ret_fire_ff, ret_fire_in;
   logic              frame_ff, frame_in;
   logic              paused_ff, paused_in;
   logic [TIME_W-1:0] pause_start_ff, pause_start_in;
   logic [TIME_W-1:0] key_ff, key_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   cell_op_type       op [DEPTH];
   entry_type         ent [DEPTH];
   logic [DEPTH-1:0]  gt;
   logic [DEPTH-1:0]  match;
   bus_type           bus;

   logic [DEPTH-1:0]  live_match;
   logic [IDX_W-1:0]  first_k;
   logic              any_match;
   logic [IDX_W-1:0]  occ_idx;
   logic [IDX_W-1:0]  pos_m1;
   entry_type         head;

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign occ_idx    = occ_ff[IDX_W-1:0];
   assign pos_m1     = pos_ff - 1'b1;
   assign head       = ent[occ_idx];

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      entry_type l_ent, r_ent;
      if (g == 0) begin : g_l0
         assign l_ent = '0;
      end else begin : g_ln
         assign l_ent = ent[g-1];
      end
      if (g == DEPTH - 1) begin : g_rn
         assign r_ent = '0;
      end else begin : g_r
         assign r_ent = ent[g+1];
      end
      smtq_cell u_cell (
         .clock     (clock),
         .op        (op[g]),
         .bus       (bus),
         .left_ent  (l_ent),
         .right_ent (r_ent),
         .ent       (ent[g]),
         .gt        (gt[g]),
         .match     (match[g])
      );
   end

   // First live entry that belongs to the id being cleared.
   always_comb begin
      first_k = '0;
      for (int i = 0; i < DEPTH; i++) begin
         live_match[i] = match[i] && (OCC_W'(i) < occ_ff);
      end
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (live_match[i]) begin
            first_k = IDX_W'(i);
         end
      end
      any_match = |live_match;
   end

   // Broadcast: the key is the compare value, the resume shift or the re-arm base.
   always_comb begin
      bus.id  = id_ff;
      bus.ent = ent[0];
      bus.key = now_ff;
      case (state_ff)
         S_IDLE: begin
            bus.key       = req_data.now - pause_start_ff;
            bus.ent.ft    = req_data.now + req_data.period;
            bus.ent.rl    = req_data.period;
            bus.ent.rep   = req_data.periodic;
            bus.ent.owner = req_data.timer_id;
         end
         S_BUB:   bus.key = key_ff;
         default: bus.key = now_ff;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      occ_in         = occ_ff;
      cnt_in         = cnt_ff;
      pos_in         = pos_ff;
      ret_fire_in    = ret_fire_ff;
      frame_in       = frame_ff;
      paused_in      = paused_ff;
      pause_start_in = pause_start_ff;
      key_in         = key_ff;
      now_in         = now_ff;
      elapsed_in     = elapsed_ff;
      id_in          = id_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = rsp_ff;
      for (int i = 0; i < DEPTH; i++) begin
         op[i] = C_HOLD;
      end
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               now_in     = req_data.now;
               elapsed_in = req_data.elapsed;
               id_in      = req_data.timer_id;
               case (kind_type'(req_data.kind))
                  K_ARM: begin
                     if (occ_ff == FULL) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = '{event_res: EV_REJECT, fired_id: req_data.timer_id,
                                   stamp: req_data.now, frame_elapsed: '0, last: 1'b1};
                     end else begin
                        op[occ_idx] = C_LOAD;
                        occ_in      = occ_ff + 1'b1;
                        pos_in      = occ_idx;
                        key_in      = req_data.now + req_data.period;
                        ret_fire_in = 1'b0;
                        if (occ_ff != '0) begin
                           state_in = S_BUB;
                        end
                     end
                  end
                  K_CLR_ID:    state_in = S_CLR;
                  K_CLR_ALL: begin
                     occ_in   = '0;
                     frame_in = 1'b0;
                  end
                  K_FRAME_ON:  frame_in = 1'b1;
                  K_FRAME_OFF: frame_in = 1'b0;
                  K_TICK: begin
                     if (!paused_ff) begin
                        cnt_in   = '0;
                        state_in = S_ROT;
                     end
                  end
                  K_PAUSE: begin
                     if (!paused_ff) begin
                        paused_in      = 1'b1;
                        pause_start_in = req_data.now;
                     end
                  end
                  K_RESUME: begin
                     if (paused_ff) begin
                        paused_in = 1'b0;
                        for (int i = 0; i < DEPTH; i++) begin
                           op[i] = C_SHIFT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         // The new entry swaps with its left neighbor while that one fires later.
         S_BUB: begin
            if (pos_ff != '0 && gt[pos_m1]) begin
               op[pos_m1] = C_TAKE_R;
               op[pos_ff] = C_TAKE_L;
               pos_in     = pos_m1;
            end else begin
               state_in = ret_fire_ff ? S_FIRE : S_IDLE;
            end
         end
         // Remove one matching entry per cycle; the tail closes up behind it.
         S_CLR: begin
            if (any_match) begin
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (IDX_W'(i) >= first_k) begin
                     op[i] = C_TAKE_R;
                  end
               end
               occ_in = occ_ff - 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         // Rotate each expired front entry to the end of the live region, so the
         // expired run ends up just past the survivors, still in queue order.
         S_ROT: begin
            if (cnt_ff < occ_ff && !gt[0]) begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (OCC_W'(i) + 1'b1 < occ_ff) begin
                     op[i] = C_TAKE_R;
                  end else if (OCC_W'(i) + 1'b1 == occ_ff) begin
                     op[i] = C_LOAD;
                  end
               end
               cnt_in = cnt_ff + 1'b1;
            end else begin
               occ_in   = occ_ff - cnt_ff;
               state_in = S_FIRE;
            end
         end
         // Report the entry after the live region, re-arm or drop it; then any frame word.
         S_FIRE: begin
            if (cnt_ff != '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in = '{event_res: EV_EXPIRED, fired_id: head.owner, stamp: now_ff,
                          frame_elapsed: '0, last: (cnt_ff == OCC_W'(1)) && !frame_ff};
               cnt_in = cnt_ff - 1'b1;
               if (head.rep) begin
                  op[occ_idx] = C_REARM;
                  occ_in      = occ_ff + 1'b1;
                  key_in      = now_ff + head.rl;
                  pos_in      = occ_idx;
                  ret_fire_in = 1'b1;
                  state_in    = S_BUB;
               end else begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     if (OCC_W'(i) >= occ_ff) begin
                        op[i] = C_TAKE_R;
                     end
                  end
               end
            end else begin
               if (frame_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in = '{event_res: EV_FRAME, fired_id: '0, stamp: now_ff,
                             frame_elapsed: elapsed_ff, last: 1'b1};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         occ_ff         <= '0;
         cnt_ff         <= '0;
         frame_ff       <= 1'b0;
         paused_ff      <= 1'b0;
         pause_start_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
         ret_fire_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         occ_ff         <= occ_in;
         cnt_ff         <= cnt_in;
         frame_ff       <= frame_in;
         paused_ff      <= paused_in;
         pause_start_ff <= pause_start_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         ret_fire_ff    <= ret_fire_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      now_ff     <= now_in;
      elapsed_ff <= elapsed_in;
      id_ff      <= id_in;
      rsp_ff     <= rsp_in;
   end

`include "sorted_multi_timer_queue_core_assert.svh"

   // The live region never outgrows the row of cells.
   `SMTQ_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= FULL)
   // Live entries plus the expired run waiting to be reported fit the row.
   `SMTQ_ASSERT_NOW(a_fire_fit, clock, reset, state_ff == S_FIRE,
                    occ_ff + cnt_ff <= FULL)
   // A bubbling entry always sits inside the live region.
   `SMTQ_ASSERT_NOW(a_bub_pos, clock, reset, state_ff == S_BUB,
                    OCC_W'(pos_ff) < occ_ff)
   // Once a word marked last is made, no expired entry is left to report.
   `SMTQ_ASSERT_NEXT(a_last_done, clock, reset, rsp_strobe_in && rsp_in.last,
                     cnt_ff == '0)

endmodule

// ===== tb/tb_sorted_multi_timer_queue_core.sv =====
module tb_sorted_multi_timer_queue_core;
   timeunit 1ns;
   timeprecision 1ps;
   import smtq_pkg::*;

   localparam int QDEPTH      = DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   // Quiet cycles after the last result: an arm word can bubble past every entry.
   localparam int DRAIN_CYCLES = 2 * QDEPTH + 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   sorted_multi_timer_queue_core #(.DEPTH(QDEPTH)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #2 clock = ~clock;

   // Shadow copy of the timer queue, kept sorted by fire time.
   logic [TIME_W-1:0] sh_fire[QDEPTH];
   logic [TIME_W-1:0] sh_reload[QDEPTH];
   logic              sh_repeat[QDEPTH];
   logic [ID_W-1:0]   sh_owner[QDEPTH];
   int                sh_count = 0;
   logic              sh_frame = 1'b0;
   logic              sh_paused = 1'b0;
   logic [TIME_W-1:0] sh_pause_at = '0;

   rsp_type expected_events[$];
   int      error_count = 0;
   int      cycle_count = 0;

   task automatic report_error(input string what, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch %0s: expected %p, got %p", what, want, got);
   endtask

   // Sorted insert: a new timer goes behind every entry with an equal fire time.
   function automatic bit timer_insert(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] rl,
                                       input logic rep, input logic [ID_W-1:0] id);
      int p;
      if (sh_count >= QDEPTH) return 1'b0;
      p = sh_count;
      while (p > 0 && sh_fire[p-1] > t) begin
         sh_fire[p] = sh_fire[p-1];
         sh_reload[p] = sh_reload[p-1];
         sh_repeat[p] = sh_repeat[p-1];
         sh_owner[p] = sh_owner[p-1];
         p--;
      end
      sh_fire[p] = t;
      sh_reload[p] = rl;
      sh_repeat[p] = rep;
      sh_owner[p] = id;
      sh_count++;
      return 1'b1;
   endfunction

   function automatic rsp_type make_event(input event_type ev, input logic [ID_W-1:0] id,
                                          input logic [TIME_W-1:0] stamp,
                                          input logic [TIME_W-1:0] fel);
      rsp_type r;
      r.event_res = ev;
      r.fired_id = id;
      r.stamp = stamp;
      r.frame_elapsed = fel;
      r.last = 1'b0;
      return r;
   endfunction

   // Applies one accepted word to the shadow queue and appends the events it must
   // produce. Returns how many were appended.
   function automatic int timer_queue_step(input req_type w);
      logic [TIME_W-1:0] hit_reload[QDEPTH];
      logic              hit_repeat[QDEPTH];
      logic [ID_W-1:0]   hit_owner[QDEPTH];
      logic [TIME_W-1:0] shift;
      int                n = 0;
      int                j = 0;
      int                hits = 0;
      case (kind_type'(w.kind))
         K_ARM:
            if (!timer_insert(w.now + w.period, w.period, w.periodic, w.timer_id)) begin
               expected_events.push_back(make_event(EV_REJECT, w.timer_id, w.now, '0));
               n++;
            end
         K_CLR_ID: begin
            for (int i = 0; i < sh_count; i++)
               if (sh_owner[i] != w.timer_id) begin
                  sh_fire[j] = sh_fire[i];
                  sh_reload[j] = sh_reload[i];
                  sh_repeat[j] = sh_repeat[i];
                  sh_owner[j] = sh_owner[i];
                  j++;
               end
            sh_count = j;
         end
         K_CLR_ALL: begin
            sh_count = 0;
            sh_frame = 1'b0;
         end
         K_FRAME_ON:  sh_frame = 1'b1;
         K_FRAME_OFF: sh_frame = 1'b0;
         K_TICK:
            if (!sh_paused) begin
               // Only entries already due when the tick starts may fire.
               while (hits < sh_count && sh_fire[hits] <= w.now) begin
                  hit_reload[hits] = sh_reload[hits];
                  hit_repeat[hits] = sh_repeat[hits];
                  hit_owner[hits] = sh_owner[hits];
                  hits++;
               end
               for (int i = hits; i < sh_count; i++) begin
                  sh_fire[i-hits] = sh_fire[i];
                  sh_reload[i-hits] = sh_reload[i];
                  sh_repeat[i-hits] = sh_repeat[i];
                  sh_owner[i-hits] = sh_owner[i];
               end
               sh_count -= hits;
               for (int i = 0; i < hits; i++) begin
                  if (hit_repeat[i])
                     void'(timer_insert(w.now + hit_reload[i], hit_reload[i], 1'b1, hit_owner[i]));
                  expected_events.push_back(make_event(EV_EXPIRED, hit_owner[i], w.now, '0));
                  n++;
               end
               if (sh_frame) begin
                  expected_events.push_back(make_event(EV_FRAME, '0, w.now, w.elapsed));
                  n++;
               end
            end
         K_PAUSE:
            if (!sh_paused) begin
               sh_paused = 1'b1;
               sh_pause_at = w.now;
            end
         default:
            if (sh_paused) begin
               shift = w.now - sh_pause_at;
               for (int i = 0; i < sh_count; i++) sh_fire[i] = sh_fire[i] + shift;
               sh_paused = 1'b0;
            end
      endcase
      if (n > 0) expected_events[$].last = 1'b1;
      return n;
   endfunction

   // Presents one word from the falling edge on and waits until the block takes it.
   task automatic send_word(input req_type w, output int produced);
      @(negedge clock);
      start = 1'b1;
      req_data = w;
      do @(posedge clock); while (busy);
      produced = timer_queue_step(w);
   endtask

   // Results are single-cycle pulses; every strobe is checked against the oldest
   // expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_events.size() == 0) begin
            report_error("unexpected word", '0, rsp_data);
         end else begin
            rsp_type want;
            want = expected_events.pop_front();
            if (rsp_data.event_res !== want.event_res ||
                rsp_data.fired_id !== want.fired_id ||
                rsp_data.stamp !== want.stamp ||
                rsp_data.frame_elapsed !== want.frame_elapsed ||
                rsp_data.last !== want.last)
               report_error("result word", want, rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** sorted_multi_timer_queue_core: FAILED **");
         $finish;
      end
   end

   typedef struct {
      req_type w;
      bit      typed;
      rsp_type want;
   } row_type;

   row_type          directed_rows[$];
   logic [TIME_W-1:0] time_base = '0;

   function automatic req_type word(input kind_type k, input logic [TIME_W-1:0] now,
                                    input logic [TIME_W-1:0] per, input logic rep,
                                    input logic [ID_W-1:0] id, input logic [TIME_W-1:0] el);
      req_type w;
      w.kind = k;
      w.now = now;
      w.elapsed = el;
      w.period = per;
      w.periodic = rep;
      w.timer_id = id;
      return w;
   endfunction

   function automatic void add_row(input req_type w, input bit typed = 1'b0,
                                   input rsp_type want = '0);
      row_type r;
      r.w = w;
      r.typed = typed;
      r.want = want;
      directed_rows.push_back(r);
   endfunction

   // Random words: a creeping time base keeps timers expiring, with an occasional
   // jump anywhere in the 32-bit range so that wrap-around gets exercised too.
   function automatic req_type random_word();
      req_type w;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 40)      w.kind = K_ARM;
      else if (pick < 65) w.kind = K_TICK;
      else if (pick < 73) w.kind = K_CLR_ID;
      else if (pick < 76) w.kind = K_CLR_ALL;
      else if (pick < 83) w.kind = K_FRAME_ON;
      else if (pick < 87) w.kind = K_FRAME_OFF;
      else if (pick < 94) w.kind = K_PAUSE;
      else                w.kind = K_RESUME;
      if ($urandom_range(19) == 0) time_base = $urandom;
      else time_base = time_base + $urandom_range(0, 30);
      w.now = time_base;
      w.elapsed = $urandom;
      w.period = ($urandom_range(99) < 85) ? $urandom_range(0, 40) : $urandom;
      w.periodic = $urandom_range(0, 1);
      w.timer_id = ($urandom_range(99) < 80) ? $urandom_range(0, 3) : $urandom_range(0, 255);
      return w;
   endfunction

   initial begin
      int sender_idle[4] = '{0, 57, 0, 32};
      int produced;

      // Empty queue, then a lone frame event, then a zero-period periodic timer
      // that must fire once per tick rather than looping.
      add_row(word(K_TICK, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0));
      add_row(word(K_FRAME_ON, 32'd1, 32'd0, 1'b0, 8'd0, 32'd0));
      add_row(word(K_TICK, 32'd5, 32'd0, 1'b0, 8'd0, 32'd7), 1'b1,
              '{event_res: EV_FRAME, fired_id: 8'd0, stamp: 32'd5, frame_elapsed: 32'd7,
                last: 1'b1});
      add_row(word(K_ARM, 32'd10, 32'd0, 1'b1, 8'hFF, 32'd0));
      add_row(word(K_TICK, 32'd10, 32'd0, 1'b0, 8'd0, 32'hFFFF_FFFF));
      add_row(word(K_FRAME_OFF, 32'd11, 32'd0, 1'b0, 8'd0, 32'd0));
      // Fill the queue with equal and wrapping fire times, then overflow it.
      for (int i = 0; i < QDEPTH - 1; i++)
         add_row(word(K_ARM, 32'd20, (i % 3 == 0) ? 32'hFFFF_FFFF : 32'(i % 4),
                      i[0], 8'(i), 32'd0));
      add_row(word(K_ARM, 32'hFFFF_FFFF, 32'd3, 1'b1, 8'h5A, 32'd0), 1'b1,
              '{event_res: EV_REJECT, fired_id: 8'h5A, stamp: 32'hFFFF_FFFF,
                frame_elapsed: 32'd0, last: 1'b1});
      add_row(word(K_CLR_ID, 32'd21, 32'd0, 1'b0, 8'hFF, 32'd0));
      // Pause handling: ticks do nothing, a second pause and a stray resume are
      // ignored, and words armed during the pause are shifted on resume too.
      add_row(word(K_PAUSE, 32'd100, 32'd0, 1'b0, 8'd0, 32'd0));
      add_row(word(K_TICK, 32'd150, 32'd0, 1'b0, 8'd0, 32'd0));
      add_row(word(K_PAUSE, 32'd160, 32'd0, 1'b0, 8'd0, 32'd0));
      add_row(word(K_ARM, 32'd170, 32'd5, 1'b0, 8'h33, 32'd0));
      add_row(word(K_RESUME, 32'd300, 32'd0, 1'b0, 8'd0, 32'd0));
      add_row(word(K_RESUME, 32'd310, 32'd0, 1'b0, 8'd0, 32'd0));
      add_row(word(K_FRAME_ON, 32'd311, 32'd0, 1'b0, 8'd0, 32'd0));
      add_row(word(K_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 8'd0, 32'h8000_0001));
      add_row(word(K_CLR_ALL, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].w, produced);
         if (directed_rows[i].typed &&
             (produced != 1 || expected_events[$] != directed_rows[i].want))
            report_error("directed prediction", directed_rows[i].want, expected_events[$]);
      end

      // Four phases of random traffic; the sender pauses between words in two of them, at two different rates.
      for (int phase = 0; phase < 4; phase++) begin
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(99) < sender_idle[phase]) begin
               @(negedge clock);
               start = 1'b0;
               repeat ($urandom_range(0, 5)) @(negedge clock);
            end
            send_word(random_word(), produced);
         end
         // Once, hold off until every outstanding result has come back.
         if (phase == 1) begin
            @(negedge clock);
            start = 1'b0;
            wait (expected_events.size() == 0);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
      end
      @(negedge clock);
      start = 1'b0;

      wait (expected_events.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("** sorted_multi_timer_queue_core: PASSED **");
      else
         $display("** sorted_multi_timer_queue_core: FAILED **");
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+src
src/smtq_pkg.sv
src/smtq_cell.sv
src/sorted_multi_timer_queue_core.sv
tb/tb_sorted_multi_timer_queue_core.sv
